/* rtl/lpm_pkg.sv */
// Shared constants and types for the IPv6 longest-prefix-match trie lookup.
// No dependencies; the interfaces and the top level import this package.
package lpm_pkg;

   // Table sizing.
   localparam int unsigned WIDE_NODES   = 2;
   localparam int unsigned NARROW_NODES = 1024;

   localparam int unsigned WIDE_BITS      = 16;
   localparam int unsigned NARROW_BITS    = 8;
   localparam int unsigned WIDE_ENTRIES   = 1 << WIDE_BITS;
   localparam int unsigned NARROW_ENTRIES = 1 << NARROW_BITS;
   localparam int unsigned ADDR_BYTES     = 16;

   localparam int unsigned WIDE_SEL_W  = (WIDE_NODES > 1) ? $clog2(WIDE_NODES) : 1;
   localparam int unsigned NODE_SEL_W  = $clog2(NARROW_NODES);
   localparam int unsigned WIDE_ADDR_W = WIDE_SEL_W + WIDE_BITS;
   localparam int unsigned NODE_ADDR_W = NODE_SEL_W + NARROW_BITS;
   localparam int unsigned WIDE_DEPTH  = WIDE_NODES * WIDE_ENTRIES;
   localparam int unsigned NODE_DEPTH  = NARROW_NODES * NARROW_ENTRIES;

   // Field widths.
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned NODE_W   = 10;
   localparam int unsigned SLOT_W   = 16;
   localparam int unsigned HOP_W    = 32;
   localparam int unsigned CHILD_W  = 10;

   // Entry layout: hop, then valid, then child index.
   localparam int unsigned ENTRY_W   = HOP_W + 1 + CHILD_W;
   localparam int unsigned VALID_BIT = HOP_W;
   localparam int unsigned CHILD_LSB = HOP_W + 1;

   // Narrow levels after the wide root: bytes 2 through 15.
   localparam int unsigned LEVELS   = ADDR_BYTES - WIDE_BITS / 8;
   localparam int unsigned LEVEL_W  = $clog2(LEVELS + 1);

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WIDE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_NARROW = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_DEFAULT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_HOP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_NODE   = 2'd2;

   typedef logic [ENTRY_W-1:0] entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

/* rtl/lpm_req_if.sv */
// Request channel of the trie lookup: lookups and table entry writes.
// Depends on lpm_pkg for the field widths.
interface lpm_req_if import lpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   addr_hi;
   logic [ADDR_W-1:0]   addr_lo;
   logic [NODE_W-1:0]   write_node;
   logic [SLOT_W-1:0]   write_slot;
   logic [HOP_W-1:0]    write_hop;
   logic                write_valid;
   logic [CHILD_W-1:0]  write_child;

   modport source (output valid, action, addr_hi, addr_lo, write_node, write_slot,
                   write_hop, write_valid, write_child, input ready);
   modport sink   (input valid, action, addr_hi, addr_lo, write_node, write_slot,
                   write_hop, write_valid, write_child, output ready);
endinterface

/* rtl/lpm_rsp_if.sv */
// Response channel of the trie lookup: one result item per request item.
// Depends on lpm_pkg for the field widths.
interface lpm_rsp_if import lpm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [HOP_W-1:0] route_hop;
   logic             hit;

   modport source (output valid, route_hop, hit, input ready);
   modport sink   (input valid, route_hop, hit, output ready);
endinterface

/* rtl/ipv6_lpm_trie_lookup_16_8.sv */
// Longest-prefix-match lookup of an IPv6 address in a 16-then-8 stride multibit trie.
// Depends on lpm_pkg, lpm_req_if and lpm_rsp_if.
//
// A lookup reads the wide root table with the first 16 address bits and then walks
// narrow nodes one address byte per cycle until a child index of zero, an out-of-range
// child, or the last byte ends the walk. Each walk step is one read of the node memory
// whose data selects the next read; a lookup visits 0 to 14 narrow nodes. The result
// is registered in the response state once the result register is free, and the block
// then returns to idle to accept the next item. A table write goes from acceptance
// straight to the response state, which registers its result. One item is worked on
// at a time; the result register lets the next item be accepted while a result still
// waits to be taken. Both tables are plain memories with no clearing: a lookup must only
// reach entries that were written before.
module ipv6_lpm_trie_lookup_16_8 import lpm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lpm_req_if.sink               req_ch,
   lpm_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Tables.
   entry_type wide_mem [0:WIDE_DEPTH-1];
   entry_type node_mem [0:NODE_DEPTH-1];

   // Configuration.
   logic             has_default_ff;
   logic [HOP_W-1:0] default_hop_ff;
   logic             root_node_ff;

   // Sequencer and walk state.
   state_type                state_ff, state_in;
   logic [2*ADDR_W-1:0]      addr_ff, addr_in;
   logic [LEVEL_W-1:0]       left_ff, left_in;
   logic                     first_ff, first_in;
   logic [HOP_W-1:0]         best_ff, best_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [HOP_W-1:0]         rsp_hop_ff, rsp_hop_in;
   logic                     rsp_hit_ff, rsp_hit_in;

   // Memory ports.
   entry_type                wide_q_ff;
   entry_type                node_q_ff;
   logic [WIDE_ADDR_W-1:0]   wide_ra;
   logic [NODE_ADDR_W-1:0]   node_ra;
   logic                     wide_we;
   logic                     node_we;
   logic [WIDE_ADDR_W-1:0]   wide_wa;
   logic [NODE_ADDR_W-1:0]   node_wa;
   entry_type                wr_entry;

   logic                     req_accept;
   logic                     root_ok;
   entry_type                entry;
   logic [CHILD_W-1:0]       child;
   logic                     descend;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign req_accept     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.route_hop = rsp_hop_ff;
   assign rsp_ch.hit     = rsp_hit_ff;

   assign root_ok = (32'(root_node_ff) < WIDE_NODES);

   // Entry writes.
   assign wr_entry = {req_ch.write_child, req_ch.write_valid, req_ch.write_hop};
   assign wide_wa  = {WIDE_SEL_W'(req_ch.write_node), req_ch.write_slot};
   assign node_wa  = {NODE_SEL_W'(req_ch.write_node), req_ch.write_slot[NARROW_BITS-1:0]};
   assign wide_we  = req_accept && (req_ch.action == ACT_WIDE)
                     && (32'(req_ch.write_node) < WIDE_NODES);
   assign node_we  = req_accept && (req_ch.action == ACT_NARROW)
                     && (32'(req_ch.write_node) < NARROW_NODES)
                     && (req_ch.write_slot[SLOT_W-1:NARROW_BITS] == '0);

   // The root read is issued straight from the request so its data arrives with the walk.
   assign wide_ra = {WIDE_SEL_W'(root_node_ff), req_ch.addr_hi[ADDR_W-1 -: WIDE_BITS]};

   // Current entry under evaluation and the decision to go one level deeper.
   assign entry   = first_ff ? wide_q_ff : node_q_ff;
   assign child   = entry[CHILD_LSB +: CHILD_W];
   assign descend = (child != '0) && (32'(child) < NARROW_NODES) && (left_ff != '0);
   assign node_ra = {NODE_SEL_W'(child), addr_ff[2*ADDR_W-1 -: NARROW_BITS]};

   always_ff @(posedge clock) begin
      if (wide_we) begin
         wide_mem[wide_wa] <= wr_entry;
      end
      wide_q_ff <= wide_mem[wide_ra];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= wr_entry;
      end
      node_q_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_default_ff <= 1'b0;
         default_hop_ff <= '0;
         root_node_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HAS_DEFAULT: has_default_ff <= csr_wdata[0];
            CSR_DEFAULT_HOP: default_hop_ff <= csr_wdata[HOP_W-1:0];
            CSR_ROOT_NODE:   root_node_ff   <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff    <= addr_in;
      left_ff    <= left_in;
      first_ff   <= first_in;
      best_ff    <= best_in;
      hit_ff     <= hit_in;
      rsp_hop_ff <= rsp_hop_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      best_in      = best_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hop_in   = rsp_hop_ff;
      rsp_hit_in   = rsp_hit_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Remaining bytes after the wide index, first byte at the top.
               addr_in  = {req_ch.addr_hi, req_ch.addr_lo} << WIDE_BITS;
               left_in  = LEVEL_W'(LEVELS);
               first_in = 1'b1;
               best_in  = '0;
               hit_in   = 1'b0;
               if (req_ch.action == ACT_LOOKUP) begin
                  if (has_default_ff) begin
                     best_in = default_hop_ff;
                     hit_in  = 1'b1;
                  end
                  state_in = root_ok ? ST_WALK : ST_RESP;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_WALK: begin
            if (entry[VALID_BIT]) begin
               best_in = entry[HOP_W-1:0];
               hit_in  = 1'b1;
            end
            first_in = 1'b0;
            if (descend) begin
               addr_in = addr_ff << NARROW_BITS;
               left_in = left_ff - 1'b1;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hop_in   = hit_ff ? best_ff : '0;
               rsp_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the IPv6 longest-prefix-match trie lookup.
// Depends on lpm_pkg, lpm_req_if, lpm_rsp_if and ipv6_lpm_trie_lookup_16_8.
module testbench import lpm_pkg::*;;

   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PHASE_ITEMS = 420;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   addr_hi;
      logic [ADDR_W-1:0]   addr_lo;
      logic [NODE_W-1:0]   write_node;
      logic [SLOT_W-1:0]   write_slot;
      logic [HOP_W-1:0]    write_hop;
      logic                write_valid;
      logic [CHILD_W-1:0]  write_child;
   } lpm_request_type;

   typedef struct {
      logic [HOP_W-1:0] route_hop;
      logic             hit;
   } route_answer_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lpm_req_if req_ch ();
   lpm_rsp_if rsp_ch ();

   ipv6_lpm_trie_lookup_16_8 dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Register copies and table contents as the block should hold them.
   bit                cfg_has_default;
   logic [HOP_W-1:0]  cfg_default_hop;
   int unsigned       cfg_root_node;
   bit [ENTRY_W-1:0]  wide_entries [int unsigned];
   bit [ENTRY_W-1:0]  node_entries [int unsigned];

   // Child pointers of every entry queued for writing so far, used only to steer lookups
   // so that each walk touches written entries alone.
   bit [CHILD_W-1:0]  planned_wide_child [int unsigned];
   bit [CHILD_W-1:0]  planned_node_child [int unsigned];
   logic [127:0]      recent_addrs [$];

   lpm_request_type   pending_requests [$];
   route_answer_type  expected_answers [$];
   lpm_request_type   offered;
   int unsigned       items_queued = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_idle_pct = 0;
   int unsigned       hold_left = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;

   // Applies one request to the table copies and returns the answer it produces.
   function automatic route_answer_type route_of(lpm_request_type rq);
      route_answer_type  ans;
      logic [127:0]      addr;
      bit [ENTRY_W-1:0]  e;
      bit [ENTRY_W-1:0]  packed_entry;
      int unsigned       node;
      ans.route_hop = '0;
      ans.hit       = 1'b0;
      addr         = {rq.addr_hi, rq.addr_lo};
      packed_entry = {rq.write_child, rq.write_valid, rq.write_hop};
      node         = 0;
      case (rq.action)
         ACT_WIDE: begin
            if (rq.write_node < WIDE_NODES)
               wide_entries[rq.write_node * WIDE_ENTRIES + rq.write_slot] = packed_entry;
         end
         ACT_NARROW: begin
            if (rq.write_node < NARROW_NODES && rq.write_slot < NARROW_ENTRIES)
               node_entries[rq.write_node * NARROW_ENTRIES + rq.write_slot] = packed_entry;
         end
         ACT_LOOKUP: begin
            if (cfg_has_default) begin
               ans.route_hop = cfg_default_hop;
               ans.hit       = 1'b1;
            end
            if (cfg_root_node < WIDE_NODES) begin
               // Byte position 1 stands for the 16-bit root read; the rest are narrow.
               for (int b = 1; b < ADDR_BYTES; b++) begin
                  if (b == 1)
                     e = wide_entries[cfg_root_node * WIDE_ENTRIES + addr[127:112]];
                  else if (node == 0 || node >= NARROW_NODES)
                     break;
                  else
                     e = node_entries[node * NARROW_ENTRIES + addr[127 - 8 * b -: 8]];
                  if (e[VALID_BIT]) begin
                     ans.route_hop = e[HOP_W-1:0];
                     ans.hit       = 1'b1;
                  end
                  node = 32'(e[CHILD_LSB +: CHILD_W]);
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic lpm_request_type random_request();
      lpm_request_type rq;
      rq.action      = ACT_NONE;
      rq.addr_hi     = {$urandom, $urandom};
      rq.addr_lo     = {$urandom, $urandom};
      rq.write_node  = NODE_W'($urandom_range(1023));
      rq.write_slot  = SLOT_W'($urandom_range(65535));
      rq.write_hop   = $urandom;
      rq.write_valid = 1'($urandom_range(1));
      rq.write_child = CHILD_W'($urandom_range(1023));
      return rq;
   endfunction

   function automatic lpm_request_type entry_write(logic [ACTION_W-1:0] act,
                                                   logic [NODE_W-1:0] node,
                                                   logic [SLOT_W-1:0] slot,
                                                   logic [CHILD_W-1:0] child);
      lpm_request_type rq;
      rq             = random_request();
      rq.action      = act;
      rq.write_node  = node;
      rq.write_slot  = slot;
      rq.write_child = child;
      return rq;
   endfunction

   // Children come mostly from a small pool so that paths share nodes.
   function automatic logic [CHILD_W-1:0] pick_child(bit deep);
      if (!deep && $urandom_range(99) < 35)
         return '0;
      case ($urandom_range(7))
         0: return 10'h3FF;
         1, 2: return CHILD_W'($urandom_range(1, 1023));
         default: return CHILD_W'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic push_request(lpm_request_type rq);
      if (rq.action == ACT_WIDE && rq.write_node < WIDE_NODES)
         planned_wide_child[rq.write_node * WIDE_ENTRIES + rq.write_slot] = rq.write_child;
      if (rq.action == ACT_NARROW && rq.write_slot < NARROW_ENTRIES)
         planned_node_child[rq.write_node * NARROW_ENTRIES + rq.write_slot] = rq.write_child;
      pending_requests.push_back(rq);
      items_queued++;
   endtask

   // Queues a lookup, first writing any entry on its path that was never written.
   task automatic queue_lookup(logic [127:0] addr, bit deep);
      lpm_request_type rq;
      int unsigned  slot;
      int unsigned  node;
      slot = cfg_root_node * WIDE_ENTRIES + addr[127:112];
      if (!planned_wide_child.exists(slot))
         push_request(entry_write(ACT_WIDE, NODE_W'(cfg_root_node), addr[127:112],
                                  pick_child(deep)));
      node = 32'(planned_wide_child[slot]);
      for (int b = 2; b < ADDR_BYTES && node != 0; b++) begin
         slot = node * NARROW_ENTRIES + addr[127 - 8 * b -: 8];
         if (!planned_node_child.exists(slot))
            push_request(entry_write(ACT_NARROW, NODE_W'(node),
                                     SLOT_W'(addr[127 - 8 * b -: 8]), pick_child(deep)));
         node = 32'(planned_node_child[slot]);
      end
      rq         = random_request();
      rq.action  = ACT_LOOKUP;
      rq.addr_hi = addr[127:64];
      rq.addr_lo = addr[63:0];
      push_request(rq);
      recent_addrs.push_back(addr);
      if (recent_addrs.size() > 32)
         void'(recent_addrs.pop_front());
   endtask

   task automatic queue_random_item();
      lpm_request_type rq;
      logic [127:0] addr;
      int unsigned  pick;
      int unsigned  keep;
      rq   = random_request();
      pick = $urandom_range(99);
      if (pick < 62) begin
         // Most lookups share a prefix with a recent address and branch off later.
         if (recent_addrs.size() == 0 || $urandom_range(9) < 3) begin
            addr = {$urandom, $urandom, $urandom, $urandom};
         end else begin
            addr = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
            keep = $urandom_range(2, 16);
            for (int b = keep; b < ADDR_BYTES; b++)
               addr[127 - 8 * b -: 8] = 8'($urandom_range(255));
         end
         queue_lookup(addr, $urandom_range(99) < 3);
      end else if (pick < 80) begin
         rq.action = ACT_NARROW;
         if ($urandom_range(3) != 0)
            rq.write_node = NODE_W'($urandom_range(1, 12));
         if ($urandom_range(19) != 0)
            rq.write_slot[15:8] = '0;
         rq.write_child = pick_child(1'b0);
         push_request(rq);
      end else if (pick < 92) begin
         rq.action = ACT_WIDE;
         if ($urandom_range(7) != 0)
            rq.write_node = NODE_W'($urandom_range(1));
         rq.write_child = pick_child(1'b0);
         push_request(rq);
      end else begin
         push_request(rq);
      end
   endtask

   task automatic program_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_HAS_DEFAULT: cfg_has_default = value[0];
         CSR_DEFAULT_HOP: cfg_default_hop = value;
         CSR_ROOT_NODE:   cfg_root_node   = 32'(value[0]);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_answers.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
      int unsigned start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start         = items_queued;
      while (items_queued - start < PHASE_ITEMS)
         queue_random_item();
      wait_idle();
   endtask

   // Request driver: offers the next pending item once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_answers.push_back(route_of(offered));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered             = pending_requests.pop_front();
               req_ch.action      <= offered.action;
               req_ch.addr_hi     <= offered.addr_hi;
               req_ch.addr_lo     <= offered.addr_lo;
               req_ch.write_node  <= offered.write_node;
               req_ch.write_slot  <= offered.write_slot;
               req_ch.write_hop   <= offered.write_hop;
               req_ch.write_valid <= offered.write_valid;
               req_ch.write_child <= offered.write_child;
               req_ch.valid       <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each taken result item with the oldest expectation.
   always @(posedge clock) begin : result_check
      route_answer_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Result with nothing expected: route_hop %h hit %b",
                           rsp_ch.route_hop, rsp_ch.hit);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_ch.route_hop !== want.route_hop || rsp_ch.hit !== want.hit) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"Result mismatch: expected route_hop %h hit %b, ",
                               "got route_hop %h hit %b"},
                              want.route_hop, want.hit, rsp_ch.route_hop, rsp_ch.hit);
               end
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off so the block fills up and stalls its input.
   always @(posedge clock) begin
      if (hold_left > 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      lpm_request_type rq;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.action      = '0;
      req_ch.addr_hi     = '0;
      req_ch.addr_lo     = '0;
      req_ch.write_node  = '0;
      req_ch.write_slot  = '0;
      req_ch.write_hop   = '0;
      req_ch.write_valid = 1'b0;
      req_ch.write_child = '0;
      rsp_ch.ready       = 1'b0;
      cfg_has_default    = 1'b0;
      cfg_default_hop    = '0;
      cfg_root_node      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: an enabled default route whose hop is zero.
      program_register(CSR_HAS_DEFAULT, 32'd1);
      program_register(CSR_DEFAULT_HOP, 32'd0);
      program_register(CSR_ROOT_NODE, 32'd0);

      rq = entry_write(ACT_WIDE, 10'd0, 16'hFFFF, 10'd0);
      rq.write_hop   = '1;
      rq.write_valid = 1'b1;
      push_request(rq);
      queue_lookup('1, 1'b0);
      rq = entry_write(ACT_WIDE, 10'd0, 16'h0000, 10'd0);
      rq.write_valid = 1'b0;
      push_request(rq);
      queue_lookup('0, 1'b0);
      // Wide writes beyond the wide nodes and narrow writes beyond slot 255 are dropped.
      rq = entry_write(ACT_WIDE, 10'd2, 16'h0000, 10'd5);
      rq.write_valid = 1'b1;
      push_request(rq);
      push_request(entry_write(ACT_WIDE, 10'h3FF, 16'hFFFF, 10'h3FF));
      queue_lookup('0, 1'b0);
      push_request(entry_write(ACT_NARROW, 10'h3FF, 16'h0100, 10'h3FF));
      push_request(entry_write(ACT_NARROW, 10'd0, 16'hFFFF, 10'd1));
      // A node that points at itself carries the walk through the last byte.
      rq = entry_write(ACT_NARROW, 10'h3FF, 16'h00FF, 10'h3FF);
      rq.write_hop   = '1;
      rq.write_valid = 1'b1;
      push_request(rq);
      rq = entry_write(ACT_NARROW, 10'h3FF, 16'h0000, 10'd0);
      rq.write_valid = 1'b0;
      push_request(rq);
      rq = entry_write(ACT_WIDE, 10'd0, 16'hFFFF, 10'h3FF);
      rq.write_hop   = '0;
      rq.write_valid = 1'b1;
      push_request(rq);
      queue_lookup('1, 1'b0);
      queue_lookup({{120{1'b1}}, 8'h00}, 1'b0);
      rq = random_request();
      push_request(rq);
      rq = random_request();
      rq.action      = ACT_LOOKUP;
      rq.addr_hi     = '1;
      rq.addr_lo     = '1;
      rq.write_node  = '1;
      rq.write_slot  = '1;
      rq.write_hop   = '1;
      rq.write_valid = 1'b1;
      rq.write_child = '1;
      push_request(rq);
      wait_idle();

      program_register(CSR_HAS_DEFAULT, 32'd0);
      program_register(CSR_DEFAULT_HOP, 32'hFFFF_FFFF);
      program_register(CSR_ROOT_NODE, 32'd1);
      run_phase(19, 81);

      program_register(CSR_HAS_DEFAULT, 32'd1);
      program_register(CSR_ROOT_NODE, 32'd0);
      run_phase(81, 19);

      program_register(CSR_DEFAULT_HOP, $urandom);
      program_register(CSR_ROOT_NODE, 32'd1);
      @(posedge clock);
      hold_left <= 400;
      run_phase(0, 0);

      program_register(CSR_HAS_DEFAULT, 32'd0);
      program_register(CSR_ROOT_NODE, 32'd0);
      run_phase(0, 0);

      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
